[hdl/fmrd_pkg.sv]
// Package for the frame maximum relative detector.
// Holds the widths, register reset values, register indexes and the issue struct.
// No dependencies; every other file but fmrd_ram imports it.
package fmrd_pkg;

  localparam int MAX_FRAME   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_FRAME);
  localparam int LEN_W       = 11;
  localparam int THR_W       = 17;
  localparam int FRAC_BITS   = 16;
  localparam int CMP_W       = SAMPLE_BITS + THR_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(39322);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1000);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = CFG_IDX_W'(1);

  // One accepted sample that owes a decision, handed from frame control to the judge.
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic signed [CMP_W-1:0] limit;
  } fmrd_issue_t;

endpackage

[hdl/fmrd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Read-first: a read and write of the same address in one cycle returns the old data.
// No dependencies.
module fmrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/fmrd_frame_ctl.sv]
// Frame control: sample position, running and prior frame maxima, and the
// threshold product for each accepted sample. Depends on fmrd_pkg.
module fmrd_frame_ctl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic signed [fmrd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [fmrd_pkg::THR_W-1:0]            threshold,
  input  logic [fmrd_pkg::LEN_W-1:0]            frame_length,
  output logic [fmrd_pkg::IDX_W-1:0]            addr,
  output fmrd_pkg::fmrd_issue_t                 issue
);
  import fmrd_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + THR_W - 1;

  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic signed [SAMPLE_BITS-1:0] run_peak_r, run_peak_nxt;
  logic signed [SAMPLE_BITS-1:0] prior_peak_r, prior_peak_nxt;
  logic                          ready_r, ready_nxt;
  logic [LEN_W-1:0]              eff_len;
  logic                          last;
  logic signed [SAMPLE_BITS-1:0] peak_upd;
  logic [PROD_W-1:0]             limit_mag;

  // Zero length acts as one, anything above the store depth saturates.
  always_comb begin
    eff_len = frame_length;
    if (frame_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (frame_length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end
  end

  assign last     = (LEN_W'(idx_r) + LEN_W'(1)) >= eff_len;
  assign peak_upd = (sample > run_peak_r) ? sample : run_peak_r;

  always_comb begin
    idx_nxt        = idx_r;
    run_peak_nxt   = run_peak_r;
    prior_peak_nxt = prior_peak_r;
    ready_nxt      = ready_r;
    if (accept) begin
      if (last) begin
        idx_nxt        = '0;
        run_peak_nxt   = '0;
        prior_peak_nxt = peak_upd;
        ready_nxt      = 1'b1;
      end else begin
        idx_nxt      = idx_r + IDX_W'(1);
        run_peak_nxt = peak_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      run_peak_r   <= '0;
      prior_peak_r <= '0;
      ready_r      <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      run_peak_r   <= run_peak_nxt;
      prior_peak_r <= prior_peak_nxt;
      ready_r      <= ready_nxt;
    end
  end

  assign addr        = idx_r;
  assign issue.valid = accept && ready_r;
  assign issue.last  = last;
  // Prior maximum times the Q0.16 threshold, both straight from registers. The
  // running maximum starts at zero, so the prior maximum is never negative and
  // its magnitude bits times the unsigned threshold give the limit exactly.
  assign limit_mag   = PROD_W'(prior_peak_r[SAMPLE_BITS-2:0]) * PROD_W'(threshold);
  assign issue.limit = CMP_W'(limit_mag);

endmodule

[hdl/fmrd_judge.sv]
// Decision stage: holds the sample's issue data beside the store read, compares,
// and keeps the result register. Depends on fmrd_pkg.
module fmrd_judge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fmrd_pkg::fmrd_issue_t                 issue,
  input  logic signed [fmrd_pkg::SAMPLE_BITS-1:0] stored,
  input  logic                                  out_stall,
  output logic                                  full,
  output logic                                  out_valid,
  output logic                                  out_detect,
  output logic                                  out_frame_end
);
  import fmrd_pkg::*;

  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_last_r;
  logic signed [CMP_W-1:0] s1_limit_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    detect_r;
  logic                    frame_end_r;
  logic                    advance;
  logic signed [CMP_W-1:0] scaled;

  assign advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign full    = s1_valid_r && out_valid_r && out_stall;
  assign scaled  = CMP_W'($signed({stored, FRAC_BITS'(0)}));

  always_comb begin
    s1_valid_nxt  = issue.valid || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1_last_r  <= issue.last;
      s1_limit_r <= issue.limit;
    end
    if (advance) begin
      detect_r    <= scaled > s1_limit_r;
      frame_end_r <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_detect    = detect_r;
  assign out_frame_end = frame_end_r;

endmodule

[hdl/frame_max_relative_detector.sv]
// Top level of the frame maximum relative detector.
// Depends on fmrd_pkg, fmrd_ram, fmrd_frame_ctl and fmrd_judge.
//
//   channel   direction   handshake             payload
//   in_       input       in_valid / in_stall   in_sample
//   out_      output      out_valid / out_stall out_detect, out_frame_end
//   cfg_      input       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is taken per clock while the input is not stalled. A decision
// leaves the result register after its sample has passed the registered frame
// store read and then the compare. Synchronous reset clears the sample position,
// both maxima and the frame-ready flag; the frame store is not cleared. The input
// stalls only when both the read stage and the result register are full and the
// result transaction is stalled, so a waiting result does not block the input.
module frame_max_relative_detector (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fmrd_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_detect,
  output logic                                    out_frame_end,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [fmrd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fmrd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import fmrd_pkg::*;

  logic [THR_W-1:0]       threshold_r, threshold_nxt;
  logic [LEN_W-1:0]       frame_length_r, frame_length_nxt;
  logic                   accept;
  logic                   full;
  logic [IDX_W-1:0]       addr;
  logic [SAMPLE_BITS-1:0] stored;
  fmrd_issue_t            issue;

  // Configuration writes are always taken; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    threshold_nxt    = threshold_r;
    frame_length_nxt = frame_length_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD:    threshold_nxt    = cfg_data[THR_W-1:0];
        CFG_FRAME_LENGTH: frame_length_nxt = cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THR_RESET;
      frame_length_r <= LEN_RESET;
    end else begin
      threshold_r    <= threshold_nxt;
      frame_length_r <= frame_length_nxt;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  fmrd_frame_ctl u_frame_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sample       (in_sample),
    .threshold    (threshold_r),
    .frame_length (frame_length_r),
    .addr         (addr),
    .issue        (issue)
  );

  // The same address is read and written in the accepting cycle; the read
  // returns the sample of the previous frame at this position.
  fmrd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (addr),
    .wdata (in_sample),
    .re    (accept),
    .raddr (addr),
    .rdata (stored)
  );

  fmrd_judge u_judge (
    .clk           (clk),
    .rst_n         (rst_n),
    .issue         (issue),
    .stored        ($signed(stored)),
    .out_stall     (out_stall),
    .full          (full),
    .out_valid     (out_valid),
    .out_detect    (out_detect),
    .out_frame_end (out_frame_end)
  );

  // The final sample of a frame always returns the position to the start.
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && issue.last |=> addr == '0)
    else $error("sample position did not wrap after frame end");

  // A decision is only owed for a sample that was actually accepted.
  a_issue_accept: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid |-> accept)
    else $error("decision issued without an accepted sample");

  // The input stalls only while a result is held by a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Right after reset no frame is stored, so no decision can be issued.
  a_first_frame: assert property (@(posedge clk)
    !rst_n |=> !issue.valid)
    else $error("decision issued before any frame was stored");

endmodule

[verif/frame_max_relative_detector_test.sv]
// Self-checking testbench for frame_max_relative_detector.
// Uses fmrd_pkg for widths, register indexes and reset values; needs only the RTL.
// A scoreboard class predicts every decision; plain tasks drive the input and register channels.
`timescale 1ns / 100ps

module frame_max_relative_detector_test;
  import fmrd_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 12;
  localparam int MAX_GAP          = 15;
  // A sample passes the store read and the compare before its decision; this
  // leaves margin so that no sample is still in flight when a register changes.
  localparam int SETTLE_CYCLES    = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_ITEMS     = 400;
  // Store entries written by the first frame; no later frame reads past them.
  localparam int FILL_LEN         = 64;
  // Samples sent while the length saturates to the store size.
  localparam int SAT_ITEMS        = 20;
  // Slowest correct run is roughly 650 samples with drawn gaps on both sides plus the
  // long hold, the drains and the register writes; this allows several times that.
  localparam int CYCLE_LIMIT      = 150000;

  // Index 3 is not a register; writes to it must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam logic [THR_W-1:0]     THR_UNITY = THR_W'(1 << FRAC_BITS);
  localparam logic [THR_W-1:0]     THR_TOP   = '1;
  localparam logic [THR_W-1:0]     THR_HALF  = THR_W'(1 << (FRAC_BITS - 1));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic detect;
    logic frame_end;
  } decision_t;

  // Keeps its own copy of the frame store, the peaks and both registers, and
  // queues the decision that each accepted sample will cause.
  class decision_scoreboard;
    logic [THR_W-1:0] threshold;
    logic [LEN_W-1:0] frame_len;
    sample_t          frame_mem [MAX_FRAME];
    int unsigned      position;
    sample_t          peak_now;
    sample_t          peak_prev;
    bit               have_prev;
    decision_t        expected_q [$];
    int               error_count;
    int               decisions_seen;

    function new();
      threshold      = THR_RESET;
      frame_len      = LEN_RESET;
      position       = 0;
      peak_now       = '0;
      peak_prev      = '0;
      have_prev      = 1'b0;
      error_count    = 0;
      decisions_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_THRESHOLD) begin
        threshold = data[THR_W-1:0];
      end else if (index == CFG_FRAME_LENGTH) begin
        frame_len = data[LEN_W-1:0];
      end
    endfunction

    function void note_sample(sample_t s);
      int unsigned span;
      int unsigned slot;
      bit          closing;
      longint      scaled_sample;
      longint      scaled_limit;
      decision_t   d;
      // A length of zero acts as one, and anything past the store size saturates.
      span = frame_len;
      if (span == 0) span = 1;
      if (span > MAX_FRAME) span = MAX_FRAME;
      slot    = (position >= MAX_FRAME) ? MAX_FRAME - 1 : position;
      closing = (slot + 1 >= span);
      if (have_prev) begin
        scaled_sample = longint'(frame_mem[slot]) <<< FRAC_BITS;
        scaled_limit  = longint'(peak_prev) * longint'(threshold);
        d.detect      = (scaled_sample > scaled_limit);
        d.frame_end   = closing;
        expected_q.push_back(d);
      end
      frame_mem[slot] = s;
      if (s > peak_now) peak_now = s;
      if (closing) begin
        peak_prev = peak_now;
        peak_now  = '0;
        position  = 0;
        have_prev = 1'b1;
      end else begin
        position = slot + 1;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("mismatch: %s", what);
    endtask

    task check_decision(logic detect, logic frame_end);
      decision_t want;
      decisions_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("decision %0d (detect %b, frame_end %b) with none expected",
                                  decisions_seen, detect, frame_end));
        return;
      end
      want = expected_q.pop_front();
      if (detect !== want.detect)
        report_mismatch($sformatf("decision %0d detect %b, expected %b",
                                  decisions_seen, detect, want.detect));
      if (frame_end !== want.frame_end)
        report_mismatch($sformatf("decision %0d frame_end %b, expected %b",
                                  decisions_seen, frame_end, want.frame_end));
    endtask

    task close_out();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d decisions never arrived", expected_q.size()));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sample_t               in_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_detect;
  logic                  out_frame_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  decision_scoreboard board;
  int                 cycle_count = 0;

  // Idle control shared between the stimulus and the result side. A calm side
  // never waits; the hold request makes the result side stall for a long stretch.
  bit send_calm     = 1'b0;
  bit recv_calm     = 1'b0;
  bit long_hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  frame_max_relative_detector DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_detect    (out_detect),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL frame_max_relative_detector");
      $finish;
    end
  end

  // Random full-scale samples as the biggest share, plus large positive values
  // that land near typical thresholds, small values around zero, and the
  // extremes of the sample range.
  function automatic sample_t draw_sample();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      v = $urandom;
    end else if (sel <= 6) begin
      v = $urandom_range(16384, 32767);
    end else if (sel <= 8) begin
      v = int'($urandom_range(0, 600)) - 300;
    end else begin
      case ($urandom_range(0, 4))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Thresholds cover zero, exactly one, values above one and the usual fractions.
  function automatic logic [THR_W-1:0] draw_threshold();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return THR_UNITY;
      2: return THR_W'($urandom_range(32'(THR_UNITY) + 1, 32'(THR_TOP)));
      default: return THR_W'($urandom_range(0, 32'(THR_UNITY)));
    endcase
  endfunction

  // Offers one sample after a drawn gap and returns once the transaction has
  // happened. Entered and left at a falling edge.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_sample(s);
    @(negedge clk);
  endtask

  // One register write transaction; the predictor takes it at the same edge.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    board.set_register(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // The sender pauses until every expected decision has come out, then lets the
  // pipeline settle. Samples of a frame that owes no decision may still be in
  // flight when the queue is empty, which the settle time covers.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: draws a stall before every decision, takes the decision on the
  // edge where out_valid is high and out_stall is low, and checks it at once.
  initial begin : result_side
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      n = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (long_hold_req) begin
        n             = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      board.check_decision(out_detect, out_frame_end);
    end
  end

  initial begin : stimulus
    int                    pick;
    int                    sel;
    int                    count;
    int                    random_sent;
    logic [LEN_W-1:0]      len_val;
    logic [CFG_DATA_W-1:0] word;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data  = '0;
    board     = new();
    random_sent = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First frame: it writes every entry that a later frame can reach, since no
    // later frame runs past FILL_LEN samples. This frame yields no decisions.
    write_register(CFG_FRAME_LENGTH, CFG_DATA_W'(FILL_LEN));
    send_sample(32767);
    send_sample(-32768);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(16384);
    repeat (FILL_LEN - 6) send_sample(draw_sample());
    wait_drain();

    // Threshold of exactly one: the stored maximum equals the limit and must
    // not be detected. The frame is cut short at four samples.
    write_register(CFG_THRESHOLD, THR_UNITY);
    write_register(CFG_FRAME_LENGTH, CFG_DATA_W'(4));
    send_sample(16384);
    send_sample(32767);
    send_sample(-32768);
    send_sample(0);
    wait_drain();

    // Threshold of zero: only strictly positive samples are detected. This
    // frame is all negative, so its maximum stays at zero.
    write_register(CFG_THRESHOLD, '0);
    send_sample(-5);
    send_sample(-32768);
    send_sample(-1);
    send_sample(-100);
    wait_drain();

    // Threshold above one, and a length of zero that acts as one sample per frame.
    write_register(CFG_THRESHOLD, THR_TOP);
    write_register(CFG_FRAME_LENGTH, '0);
    send_sample(100);
    send_sample(7);
    send_sample(50);
    wait_drain();

    // Half threshold against a maximum of 200: a sample of 100 sits exactly on
    // the limit, 101 just above it. A write to the spare index changes nothing.
    write_register(CFG_THRESHOLD, THR_HALF);
    write_register(CFG_FRAME_LENGTH, CFG_DATA_W'(3));
    write_register(CFG_SPARE, '1);
    send_sample(200);
    send_sample(100);
    send_sample(101);
    send_sample(-1);
    send_sample(-1);
    send_sample(-1);
    wait_drain();

    // An all-ones length write saturates to the store size, so the frame runs on
    // past every shorter length while staying inside the filled entries. A
    // shorter length then ends that frame at its next sample.
    write_register(CFG_FRAME_LENGTH, '1);
    repeat (SAT_ITEMS) send_sample(draw_sample());
    wait_drain();
    write_register(CFG_FRAME_LENGTH, CFG_DATA_W'(4));
    repeat (4) send_sample(draw_sample());
    wait_drain();

    // Backpressure: the sender offers without gaps while the result side holds
    // off for a long stretch, so the pipeline fills and the input stalls.
    write_register(CFG_THRESHOLD, draw_threshold());
    write_register(CFG_FRAME_LENGTH, CFG_DATA_W'(8));
    send_calm     = 1'b1;
    recv_calm     = 1'b0;
    long_hold_req = 1'b1;
    repeat (80) send_sample(draw_sample());
    send_calm = 1'b0;

    // Random phases. Each one drains, rewrites one or both registers and sends
    // a burst whose length is unrelated to the frame length, so frames are often
    // cut or stretched by the next setting. Lengths stay within the filled part
    // of the store. Upper data bits of a length write are random and must be
    // ignored.
    while (random_sent < RANDOM_ITEMS) begin
      wait_drain();
      pick = $urandom_range(0, 3);
      if (pick != 1) write_register(CFG_THRESHOLD, draw_threshold());
      if (pick != 0) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: len_val = '0;
          1: len_val = LEN_W'(1);
          2: len_val = LEN_W'($urandom_range(17, FILL_LEN));
          default: len_val = LEN_W'($urandom_range(1, 16));
        endcase
        word = CFG_DATA_W'(len_val);
        word[CFG_DATA_W-1:LEN_W] = $urandom;
        write_register(CFG_FRAME_LENGTH, word);
      end
      if (pick == 3 && $urandom_range(0, 3) == 0)
        write_register(CFG_SPARE, CFG_DATA_W'($urandom));
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      count = $urandom_range(5, 60);
      repeat (count) send_sample(draw_sample());
      random_sent += count;
    end

    send_calm = 1'b0;
    recv_calm = 1'b0;
    wait_drain();
    board.close_out();

    if (board.error_count == 0) begin
      $display("PASS frame_max_relative_detector");
    end else begin
      $display("FAIL frame_max_relative_detector");
    end
    $finish;
  end

endmodule
